### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lav_pkg.sv
`default_nettype none

package lav_pkg;

   localparam int LAV_FRAC_BITS = 16;
   localparam int LAV_POS_W     = 32;
   localparam int LAV_AXIS_W    = 18;
   // Magnitudes are aligned so that the largest has its top bit at this width minus one
   localparam int LAV_MAG_W     = 30;

   localparam int LAV_REQ_W     = 6 * LAV_POS_W;
   localparam int LAV_RSP_BITS  = 9 * LAV_AXIS_W + 3 * LAV_POS_W;
   localparam int LAV_RSP_W     = ((LAV_RSP_BITS + 7) / 8) * 8;

   localparam int LAV_CSR_AW    = 2;

   localparam logic [LAV_CSR_AW-1:0] LAV_REG_UP_X = 2'd0;
   localparam logic [LAV_CSR_AW-1:0] LAV_REG_UP_Y = 2'd1;
   localparam logic [LAV_CSR_AW-1:0] LAV_REG_UP_Z = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/lav_norm.sv
`default_nettype none

module lav_norm #(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS,
   parameter int SIDE_W    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [2:0][IN_W-1:0]          in_vec,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [2:0][FRAC_BITS+1:0]     out_vec,
   output logic [SIDE_W-1:0]             out_side
);
   import lav_pkg::*;

   localparam int AXW  = FRAC_BITS + 2;
   localparam int MAGW = LAV_MAG_W;
   localparam int TOP  = MAGW - 1;
   localparam int NG   = (IN_W + 7) / 8;
   localparam int PW   = $clog2(NG * 8);
   localparam int SQW  = 2 * MAGW + 2;
   localparam int RW   = MAGW + 1;
   localparam int QW   = FRAC_BITS + 1;
   localparam int NW   = MAGW + 1 + FRAC_BITS;
   localparam int TGW  = SIDE_W + 4;

   // tag: side payload, zero flag (bit 3), component signs (bits 2:0)

   // stage A: magnitudes
   logic [2:0][IN_W-1:0] a_mag_in, a_mag_ff;
   logic [2:0]           a_neg_in;
   logic [IN_W-1:0]      a_or_in, a_or_ff;
   logic [TGW-1:0]       a_tag_ff;
   logic                 a_vld_ff;

   always_comb begin
      a_or_in = '0;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_vec[i][IN_W-1];
         a_mag_in[i] = a_neg_in[i] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
         a_or_in     = a_or_in | a_mag_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= in_valid;
      end
      if (ce) begin
         a_mag_ff <= a_mag_in;
         a_or_ff  <= a_or_in;
         a_tag_ff <= {in_side, 1'b0, a_neg_in};
      end
   end

   // stage B: leading one inside each byte group
   logic [NG*8-1:0]      b_pad;
   logic [NG-1:0]        b_gnz_in, b_gnz_ff;
   logic [NG-1:0][2:0]   b_gpos_in, b_gpos_ff;
   logic [2:0][IN_W-1:0] b_mag_ff;
   logic [TGW-1:0]       b_tag_ff;
   logic                 b_vld_ff;

   always_comb begin
      b_pad = (NG * 8)'(a_or_ff);
      for (int g = 0; g < NG; g++) begin
         b_gnz_in[g]  = |b_pad[g*8 +: 8];
         b_gpos_in[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (b_pad[g*8 + b]) begin
               b_gpos_in[g] = 3'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (ce) begin
         b_vld_ff <= a_vld_ff;
      end
      if (ce) begin
         b_gnz_ff  <= b_gnz_in;
         b_gpos_ff <= b_gpos_in;
         b_mag_ff  <= a_mag_ff;
         b_tag_ff  <= a_tag_ff;
      end
   end

   // stage C: pick the highest non-empty group
   logic [PW-1:0]        c_pos_in, c_pos_ff;
   logic                 c_zero_in;
   logic [2:0][IN_W-1:0] c_mag_ff;
   logic [TGW-1:0]       c_tag_ff;
   logic                 c_vld_ff;

   always_comb begin
      c_pos_in  = '0;
      c_zero_in = 1'b1;
      for (int g = 0; g < NG; g++) begin
         if (b_gnz_ff[g]) begin
            c_pos_in  = PW'(g * 8) + PW'(b_gpos_ff[g]);
            c_zero_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (ce) begin
         c_vld_ff <= b_vld_ff;
      end
      if (ce) begin
         c_pos_ff <= c_pos_in;
         c_mag_ff <= b_mag_ff;
         c_tag_ff <= {b_tag_ff[TGW-1:4], c_zero_in, b_tag_ff[2:0]};
      end
   end

   // stage D: align so the largest magnitude lands in [2^29, 2^30)
   logic [PW-1:0]              d_rsh, d_lsh;
   logic [IN_W+MAGW-1:0]       d_wide;
   logic [2:0][MAGW-1:0]       d_mag_in, d_mag_ff;
   logic [TGW-1:0]             d_tag_ff;
   logic                       d_vld_ff;

   always_comb begin
      d_wide = '0;
      if (c_pos_ff >= PW'(TOP)) begin
         d_rsh = c_pos_ff - PW'(TOP);
         d_lsh = '0;
      end else begin
         d_rsh = '0;
         d_lsh = PW'(TOP) - c_pos_ff;
      end
      for (int i = 0; i < 3; i++) begin
         d_wide      = ((IN_W + MAGW)'(c_mag_ff[i]) >> d_rsh) << d_lsh;
         d_mag_in[i] = d_wide[MAGW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (ce) begin
         d_vld_ff <= c_vld_ff;
      end
      if (ce) begin
         d_mag_ff <= d_mag_in;
         d_tag_ff <= c_tag_ff;
      end
   end

   // stage E: squares
   logic [2:0][2*MAGW-1:0] e_sq_in, e_sq_ff;
   logic [2:0][MAGW-1:0]   e_mag_ff;
   logic [TGW-1:0]         e_tag_ff;
   logic                   e_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_sq_in[i] = (2 * MAGW)'(d_mag_ff[i]) * (2 * MAGW)'(d_mag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (ce) begin
         e_vld_ff <= d_vld_ff;
      end
      if (ce) begin
         e_sq_ff  <= e_sq_in;
         e_mag_ff <= d_mag_ff;
         e_tag_ff <= d_tag_ff;
      end
   end

   // stage F and square root: one root bit per stage
   logic [SQW:0]         sq_rem_ff  [0:RW];
   logic [RW-1:0]        sq_root_ff [0:RW];
   logic [2:0][MAGW-1:0] sq_mag_ff  [0:RW];
   logic [TGW-1:0]       sq_tag_ff  [0:RW];
   logic                 sq_vld_ff  [0:RW];
   logic [SQW:0]         f_sum_in;

   assign f_sum_in = (SQW + 1)'(e_sq_ff[0]) + (SQW + 1)'(e_sq_ff[1])
                   + (SQW + 1)'(e_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (ce) begin
         sq_vld_ff[0] <= e_vld_ff;
      end
      if (ce) begin
         sq_rem_ff[0]  <= f_sum_in;
         sq_root_ff[0] <= '0;
         sq_mag_ff[0]  <= e_mag_ff;
         sq_tag_ff[0]  <= e_tag_ff;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int B = RW - 1 - k;
      logic [SQW:0] inc;
      logic         take;

      always_comb begin
         inc  = ((SQW + 1)'(sq_root_ff[k]) << (B + 1)) + ((SQW + 1)'(1) << (2 * B));
         take = sq_rem_ff[k] >= inc;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (ce) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         if (ce) begin
            sq_rem_ff[k+1]  <= take ? (sq_rem_ff[k] - inc) : sq_rem_ff[k];
            sq_root_ff[k+1] <= sq_root_ff[k] | (take ? (RW'(1) << B) : RW'(0));
            sq_mag_ff[k+1]  <= sq_mag_ff[k];
            sq_tag_ff[k+1]  <= sq_tag_ff[k];
         end
      end
   end

   // divide: q = (mag * 2^F + len / 2) / len, one quotient bit per stage
   logic [RW-1:0]        dv_len_ff [0:QW];
   logic [2:0][RW-1:0]   dv_rem_ff [0:QW];
   logic [2:0][QW-1:0]   dv_n_ff   [0:QW];
   logic [2:0][QW-1:0]   dv_q_ff   [0:QW];
   logic [TGW-1:0]       dv_tag_ff [0:QW];
   logic                 dv_vld_ff [0:QW];
   logic [2:0][NW-1:0]   p_num_in;
   logic [2:0][RW-1:0]   p_rem_in;
   logic [2:0][QW-1:0]   p_n_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_num_in[i] = (NW'(sq_mag_ff[RW][i]) << FRAC_BITS) + NW'(sq_root_ff[RW] >> 1);
         p_rem_in[i] = RW'(p_num_in[i][NW-1:QW]);
         p_n_in[i]   = p_num_in[i][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (ce) begin
         dv_vld_ff[0] <= sq_vld_ff[RW];
      end
      if (ce) begin
         dv_len_ff[0] <= sq_root_ff[RW];
         dv_rem_ff[0] <= p_rem_in;
         dv_n_ff[0]   <= p_n_in;
         dv_q_ff[0]   <= '0;
         dv_tag_ff[0] <= sq_tag_ff[RW];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [2:0][RW:0]   t;
      logic [2:0]         ge;
      logic [2:0][RW-1:0] rem_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i]      = {dv_rem_ff[k][i], dv_n_ff[k][i][QW-1]};
            ge[i]     = t[i] >= {1'b0, dv_len_ff[k]};
            rem_in[i] = ge[i] ? RW'(t[i] - {1'b0, dv_len_ff[k]}) : RW'(t[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (ce) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         if (ce) begin
            dv_len_ff[k+1] <= dv_len_ff[k];
            dv_rem_ff[k+1] <= rem_in;
            dv_tag_ff[k+1] <= dv_tag_ff[k];
            for (int i = 0; i < 3; i++) begin
               dv_n_ff[k+1][i] <= dv_n_ff[k][i] << 1;
               dv_q_ff[k+1][i] <= {dv_q_ff[k][i][QW-2:0], ge[i]};
            end
         end
      end
   end

   // output: apply signs, force zero for a zero-length vector
   logic [2:0][AXW-1:0] o_vec_in;
   logic                o_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_tag_ff[QW][3]) begin
            o_vec_in[i] = '0;
         end else if (dv_tag_ff[QW][i]) begin
            o_vec_in[i] = AXW'(0) - AXW'(dv_q_ff[QW][i]);
         end else begin
            o_vec_in[i] = AXW'(dv_q_ff[QW][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (ce) begin
         o_vld_ff <= dv_vld_ff[QW];
      end
      if (ce) begin
         out_vec  <= o_vec_in;
         out_side <= dv_tag_ff[QW][TGW-1:4];
      end
   end

   assign out_valid = o_vld_ff;

endmodule

`default_nettype wire

### hw/rtl/look_at_view_matrix_top.sv
`default_nettype none
// Channel   Dir  Ports                              Word
// request   in   req_tvalid/req_tready/req_tdata    eye and target point
// response  out  rsp_tvalid/rsp_tready/rsp_tdata    view axes and translation
// csr       in   csr_we/csr_addr/csr_wdata          world up vector
//
// One word in per cycle while the response is not stalled; the pipeline holds three
// normalisers, each a one-bit-per-stage square root and divider.
// Synchronous active-high reset clears the pipeline valid bits and sets the up vector to (0, 1.0, 0).
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.

module look_at_view_matrix_top #(
   parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z
   input  logic [lav_pkg::LAV_REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // right_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z, zero fill
   output logic [lav_pkg::LAV_RSP_W-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [lav_pkg::LAV_CSR_AW-1:0] csr_addr,
   input  logic [lav_pkg::LAV_AXIS_W-1:0] csr_wdata
);
   import lav_pkg::*;

   localparam int AXW = FRAC_BITS + 2;
   localparam int UPW = (AXW > LAV_AXIS_W) ? AXW : LAV_AXIS_W;
   localparam int DW  = LAV_POS_W + 1;
   localparam int C1W = UPW + AXW + 1;
   localparam int C2W = 2 * AXW + 1;
   localparam int PRW = LAV_POS_W + AXW;
   localparam int DSW = PRW + 2;
   localparam int RMW = DSW + 1 - FRAC_BITS;
   localparam int EW  = 3 * LAV_POS_W;
   localparam int S2W = EW + 3 * AXW;
   localparam int S3W = EW + 6 * AXW;

   logic ce;

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   // world up vector
   logic [2:0][UPW-1:0] up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= '0;
         up_ff[1] <= UPW'(1) << FRAC_BITS;
         up_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            LAV_REG_UP_X: up_ff[0] <= UPW'($signed(csr_wdata));
            LAV_REG_UP_Y: up_ff[1] <= UPW'($signed(csr_wdata));
            LAV_REG_UP_Z: up_ff[2] <= UPW'($signed(csr_wdata));
            default: ;
         endcase
      end
   end

   // stage 0: eye minus target
   logic [2:0][LAV_POS_W-1:0] s0_eye_ff;
   logic [2:0][DW-1:0]        s0_diff_in, s0_diff_ff;
   logic                      s0_vld_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s0_diff_in[c] = DW'($signed(req_tdata[c*LAV_POS_W +: LAV_POS_W]))
                       - DW'($signed(req_tdata[(3+c)*LAV_POS_W +: LAV_POS_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (ce) begin
         s0_vld_ff <= req_tvalid;
      end
      if (ce) begin
         s0_diff_ff <= s0_diff_in;
         for (int c = 0; c < 3; c++) begin
            s0_eye_ff[c] <= req_tdata[c*LAV_POS_W +: LAV_POS_W];
         end
      end
   end

   // backward axis
   logic                n1_vld;
   logic [2:0][AXW-1:0] n1_back;
   logic [EW-1:0]       n1_side;

   lav_norm #(.IN_W(DW), .FRAC_BITS(FRAC_BITS), .SIDE_W(EW)) u_norm_back (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(s0_vld_ff), .in_vec(s0_diff_ff), .in_side(s0_eye_ff),
      .out_valid(n1_vld), .out_vec(n1_back), .out_side(n1_side)
   );

   // cross(up, back)
   logic signed [UPW+AXW-1:0] x1_p_in [6];
   logic signed [UPW+AXW-1:0] x1_p_ff [6];
   logic [S2W-1:0]            x1_side_ff, x2_side_ff;
   logic                      x1_vld_ff, x2_vld_ff;
   logic [2:0][C1W-1:0]       x2_c_in, x2_c_ff;

   always_comb begin
      x1_p_in[0] = $signed(up_ff[1]) * $signed(n1_back[2]);
      x1_p_in[1] = $signed(up_ff[2]) * $signed(n1_back[1]);
      x1_p_in[2] = $signed(up_ff[2]) * $signed(n1_back[0]);
      x1_p_in[3] = $signed(up_ff[0]) * $signed(n1_back[2]);
      x1_p_in[4] = $signed(up_ff[0]) * $signed(n1_back[1]);
      x1_p_in[5] = $signed(up_ff[1]) * $signed(n1_back[0]);
      x2_c_in[0] = C1W'(x1_p_ff[0]) - C1W'(x1_p_ff[1]);
      x2_c_in[1] = C1W'(x1_p_ff[2]) - C1W'(x1_p_ff[3]);
      x2_c_in[2] = C1W'(x1_p_ff[4]) - C1W'(x1_p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_vld_ff <= 1'b0;
         x2_vld_ff <= 1'b0;
      end else if (ce) begin
         x1_vld_ff <= n1_vld;
         x2_vld_ff <= x1_vld_ff;
      end
      if (ce) begin
         x1_p_ff    <= x1_p_in;
         x1_side_ff <= {n1_back, n1_side};
         x2_c_ff    <= x2_c_in;
         x2_side_ff <= x1_side_ff;
      end
   end

   // right axis
   logic                n2_vld;
   logic [2:0][AXW-1:0] n2_right;
   logic [S2W-1:0]      n2_side;
   logic [2:0][AXW-1:0] n2_back;

   lav_norm #(.IN_W(C1W), .FRAC_BITS(FRAC_BITS), .SIDE_W(S2W)) u_norm_right (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(x2_vld_ff), .in_vec(x2_c_ff), .in_side(x2_side_ff),
      .out_valid(n2_vld), .out_vec(n2_right), .out_side(n2_side)
   );

   assign n2_back = n2_side[S2W-1:EW];

   // cross(back, right)
   logic signed [2*AXW-1:0] y1_p_in [6];
   logic signed [2*AXW-1:0] y1_p_ff [6];
   logic [S3W-1:0]          y1_side_ff, y2_side_ff;
   logic                    y1_vld_ff, y2_vld_ff;
   logic [2:0][C2W-1:0]     y2_c_in, y2_c_ff;

   always_comb begin
      y1_p_in[0] = $signed(n2_back[1]) * $signed(n2_right[2]);
      y1_p_in[1] = $signed(n2_back[2]) * $signed(n2_right[1]);
      y1_p_in[2] = $signed(n2_back[2]) * $signed(n2_right[0]);
      y1_p_in[3] = $signed(n2_back[0]) * $signed(n2_right[2]);
      y1_p_in[4] = $signed(n2_back[0]) * $signed(n2_right[1]);
      y1_p_in[5] = $signed(n2_back[1]) * $signed(n2_right[0]);
      y2_c_in[0] = C2W'(y1_p_ff[0]) - C2W'(y1_p_ff[1]);
      y2_c_in[1] = C2W'(y1_p_ff[2]) - C2W'(y1_p_ff[3]);
      y2_c_in[2] = C2W'(y1_p_ff[4]) - C2W'(y1_p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_vld_ff <= 1'b0;
         y2_vld_ff <= 1'b0;
      end else if (ce) begin
         y1_vld_ff <= n2_vld;
         y2_vld_ff <= y1_vld_ff;
      end
      if (ce) begin
         y1_p_ff    <= y1_p_in;
         y1_side_ff <= {n2_right, n2_side};
         y2_c_ff    <= y2_c_in;
         y2_side_ff <= y1_side_ff;
      end
   end

   // camera up axis
   logic                      n3_vld;
   logic [2:0][AXW-1:0]       n3_upward;
   logic [S3W-1:0]            n3_side;
   logic [2:0][2:0][AXW-1:0]  n3_axes;
   logic [2:0][LAV_POS_W-1:0] n3_eye;

   lav_norm #(.IN_W(C2W), .FRAC_BITS(FRAC_BITS), .SIDE_W(S3W)) u_norm_upward (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(y2_vld_ff), .in_vec(y2_c_ff), .in_side(y2_side_ff),
      .out_valid(n3_vld), .out_vec(n3_upward), .out_side(n3_side)
   );

   // axes in output order: right, upward, back
   assign n3_axes[0] = n3_side[S3W-1:S2W];
   assign n3_axes[1] = n3_upward;
   assign n3_axes[2] = n3_side[S2W-1:EW];
   assign n3_eye     = n3_side[EW-1:0];

   // translation: products, negated sum, round and saturate
   logic [2:0][2:0][PRW-1:0] t1_p_in, t1_p_ff;
   logic [2:0][2:0][AXW-1:0] t1_axes_ff, t2_axes_ff, o_axes_ff;
   logic [2:0][DSW-1:0]      t2_sum;
   logic [2:0][DSW-1:0]      t2_mag_in, t2_mag_ff;
   logic [2:0]               t2_neg_in, t2_neg_ff;
   logic [2:0][RMW-1:0]      t3_r;
   logic [2:0][LAV_POS_W-1:0] o_shift_in, o_shift_ff;
   logic                     t1_vld_ff, t2_vld_ff, o_vld_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            t1_p_in[a][c] = $signed(n3_eye[c]) * $signed(n3_axes[a][c]);
         end
         t2_sum[a] = DSW'($signed(t1_p_ff[a][0])) + DSW'($signed(t1_p_ff[a][1]))
                   + DSW'($signed(t1_p_ff[a][2]));
         // a positive dot gives a negative shift
         t2_neg_in[a] = !t2_sum[a][DSW-1] && (t2_sum[a] != '0);
         t2_mag_in[a] = t2_sum[a][DSW-1] ? (DSW'(0) - t2_sum[a]) : t2_sum[a];
         t3_r[a] = RMW'(((DSW + 1)'(t2_mag_ff[a])
                       + ((DSW + 1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
         if (t2_neg_ff[a]) begin
            if (t3_r[a] > (RMW'(1) << (LAV_POS_W - 1))) begin
               o_shift_in[a] = {1'b1, {(LAV_POS_W-1){1'b0}}};
            end else begin
               o_shift_in[a] = LAV_POS_W'(RMW'(0) - t3_r[a]);
            end
         end else if (t3_r[a] > RMW'({(LAV_POS_W-1){1'b1}})) begin
            o_shift_in[a] = {1'b0, {(LAV_POS_W-1){1'b1}}};
         end else begin
            o_shift_in[a] = LAV_POS_W'(t3_r[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else if (ce) begin
         t1_vld_ff <= n3_vld;
         t2_vld_ff <= t1_vld_ff;
         o_vld_ff  <= t2_vld_ff;
      end
      if (ce) begin
         t1_p_ff    <= t1_p_in;
         t1_axes_ff <= n3_axes;
         t2_mag_ff  <= t2_mag_in;
         t2_neg_ff  <= t2_neg_in;
         t2_axes_ff <= t1_axes_ff;
         o_shift_ff <= o_shift_in;
         o_axes_ff  <= t2_axes_ff;
      end
   end

   // pack the response word
   always_comb begin
      rsp_tdata = '0;
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            rsp_tdata[(a*3 + c)*LAV_AXIS_W +: LAV_AXIS_W] =
               LAV_AXIS_W'($signed(o_axes_ff[a][c]));
         end
         rsp_tdata[9*LAV_AXIS_W + a*LAV_POS_W +: LAV_POS_W] = o_shift_ff[a];
      end
   end

   assign rsp_tvalid = o_vld_ff;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_take_enters, req_tvalid && req_tready, s0_vld_ff,
                "accepted word did not enter the pipeline")
   `ASSERT_IMPL(a_stall_blocks, rsp_tvalid && !rsp_tready, !req_tready,
                "request taken while response stalled")
   `ASSERT_IMPL(a_zero_right, o_vld_ff && (o_axes_ff[0] == '0), o_shift_ff[0] == '0,
                "zero right axis with non-zero shift")
   `ASSERT_IMPL(a_zero_back, o_vld_ff && (o_axes_ff[2] == '0),
                (o_axes_ff[0] == '0) && (o_axes_ff[1] == '0),
                "zero back axis with non-zero side axes")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lav_pkg::*;

   localparam int FB = LAV_FRAC_BITS;
   localparam int AW = LAV_AXIS_W;
   localparam int PW = LAV_POS_W;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = 200;

   class view_basis_board;
      longint up_vec[3];
      logic [LAV_RSP_W-1:0] expected_words[$];
      int errors;
      int checked;

      function new();
         up_vec[0] = 0;
         up_vec[1] = longint'(1) << FB;
         up_vec[2] = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void set_up(logic [LAV_CSR_AW-1:0] idx, logic [AW-1:0] val);
         if (idx == LAV_REG_UP_X) up_vec[0] = longint'($signed(val));
         else if (idx == LAV_REG_UP_Y) up_vec[1] = longint'($signed(val));
         else if (idx == LAV_REG_UP_Z) up_vec[2] = longint'($signed(val));
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = longint'(1) << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function void unit(input longint v[3], output longint o[3]);
         longint unsigned mag[3];
         bit neg[3];
         longint unsigned m, sum, len, q;
         m = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
         end
         if (m == 0) begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return;
         end
         while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
         end
         for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
         len = root(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
         end
      endfunction

      function void cross3(input longint a[3], input longint b[3], output longint r[3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function logic [PW-1:0] shift_of(input longint e[3], input longint ax[3]);
         longint n, r;
         longint unsigned half;
         half = 64'd1 << (FB - 1);
         n = -(e[0] * ax[0] + e[1] * ax[1] + e[2] * ax[2]);
         if (n >= 0) r = longint'((longint'(n) + half) >> FB);
         else r = -longint'((longint'(-n) + half) >> FB);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[PW-1:0];
      endfunction

      // Work out the basis and translation for one accepted word.
      function void note(logic [LAV_REQ_W-1:0] d);
         longint eye[3], dv[3], tmp[3], bk[3], rt[3], uw[3];
         logic [LAV_RSP_W-1:0] w;
         for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(d[i*PW +: PW]));
            dv[i] = eye[i] - longint'($signed(d[(3+i)*PW +: PW]));
         end
         unit(dv, bk);
         cross3(up_vec, bk, tmp);
         unit(tmp, rt);
         cross3(bk, rt, tmp);
         unit(tmp, uw);
         w = '0;
         for (int i = 0; i < 3; i++) begin
            w[i*AW +: AW] = rt[i][AW-1:0];
            w[(3+i)*AW +: AW] = uw[i][AW-1:0];
            w[(6+i)*AW +: AW] = bk[i][AW-1:0];
         end
         w[9*AW +: PW] = shift_of(eye, rt);
         w[9*AW+PW +: PW] = shift_of(eye, uw);
         w[9*AW+2*PW +: PW] = shift_of(eye, bk);
         expected_words.push_back(w);
      endfunction

      function void check(logic [LAV_RSP_W-1:0] got);
         logic [LAV_RSP_W-1:0] exp_w;
         int lo, wd;
         bit bad;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response word with nothing outstanding: %h", got);
            return;
         end
         exp_w = expected_words.pop_front();
         checked++;
         bad = 0;
         for (int f = 0; f < 12; f++) begin
            lo = (f < 9) ? f * AW : 9 * AW + (f - 9) * PW;
            wd = (f < 9) ? AW : PW;
            if (((got >> lo) ^ (exp_w >> lo)) & ((64'd1 << wd) - 1)) begin
               if (!bad && errors < 10)
                  $display("response %0d field %0d: expected %h got %h",
                           checked, f, (exp_w >> lo) & ((64'd1 << wd) - 1),
                           (got >> lo) & ((64'd1 << wd) - 1));
               bad = 1;
            end
         end
         if (bad) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic [LAV_REQ_W-1:0] req_tdata = '0;
   logic rsp_tready = 0;
   logic csr_we = 0;
   logic [LAV_CSR_AW-1:0] csr_addr = '0;
   logic [AW-1:0] csr_wdata = '0;
   wire req_tready;
   wire rsp_tvalid;
   wire [LAV_RSP_W-1:0] rsp_tdata;

   view_basis_board board = new();
   int tx_idle = 0;
   int rx_idle = 0;
   int quiet_cycles = 0;

   look_at_view_matrix_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check(rsp_tdata);
         if (csr_we) board.set_up(csr_addr, csr_wdata);
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle);
   end

   // Count cycles with no word moving on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("look_at_view_matrix_top regression: fail");
         $finish;
      end
   end

   task automatic send(logic [LAV_REQ_W-1:0] d);
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_up(logic [LAV_CSR_AW-1:0] idx, int val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val[AW-1:0];
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [LAV_REQ_W-1:0] pack(int e[3], int a[3]);
      logic [LAV_REQ_W-1:0] d;
      for (int i = 0; i < 3; i++) begin
         d[i*PW +: PW] = e[i];
         d[(3+i)*PW +: PW] = a[i];
      end
      return d;
   endfunction

   // Mostly modest scenes, some full-range words, some aimed along the up vector.
   function automatic logic [LAV_REQ_W-1:0] random_scene();
      int e[3], a[3];
      int k, pick;
      pick = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         if (pick < 3) begin
            e[i] = $urandom;
            a[i] = $urandom;
         end else begin
            e[i] = int'($urandom_range(2 << 22)) - (1 << 22);
            a[i] = (pick == 3) ? e[i] + int'($urandom_range(6)) - 3
                               : int'($urandom_range(2 << 22)) - (1 << 22);
         end
      end
      if (pick == 4) begin
         k = int'($urandom_range(64)) - 32;
         for (int i = 0; i < 3; i++) a[i] = e[i] + k * int'(board.up_vec[i]);
      end
      if (pick == 5) a = e;
      return pack(e, a);
   endfunction

   task automatic directed();
      int e[3], a[3];
      int mx, mn;
      mx = 32'sh7fffffff;
      mn = 32'sh80000000;
      e = '{0, 0, 0}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{mx, mx, mx}; a = '{mx, mx, mx}; send(pack(e, a));
      e = '{mx, mx, mx}; a = '{mn, mn, mn}; send(pack(e, a));
      e = '{mn, mn, mn}; a = '{mx, mx, mx}; send(pack(e, a));
      e = '{mx, mn, mx}; a = '{mn, mx, mn}; send(pack(e, a));
      e = '{mn, 0, mx}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{0, 5 << 16, 0}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{0, 0, 0}; a = '{0, 7 << 16, 0}; send(pack(e, a));
      e = '{1, 0, 0}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{0, 0, 1}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{-1, -1, -1}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{3 << 16, 4 << 16, 5 << 16}; a = '{0, 0, 0}; send(pack(e, a));
      e = '{mx, 0, 0}; a = '{0, 0, mn}; send(pack(e, a));
      e = '{100 << 16, -200 << 16, 300 << 16}; a = '{1 << 16, 2 << 16, -3 << 16};
      send(pack(e, a));
      e = '{mn, mn, 0}; a = '{mn, mn, 1}; send(pack(e, a));
   endtask

   initial begin
      int ups[6][3];
      ups = '{'{0, 65536, 0}, '{-65536, 0, 0}, '{65536, -65536, 65536},
              '{0, 0, 0}, '{-65536, -65536, -65536}, '{1, 12345, -40000}};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      for (int p = 0; p < 6; p++) begin
         drain();
         write_up(LAV_REG_UP_X, ups[p][0]);
         write_up(LAV_REG_UP_Y, ups[p][1]);
         write_up(LAV_REG_UP_Z, ups[p][2]);
         // index three has no register behind it
         write_up(2'd3, $urandom);
         if (p == 3) directed();
         for (int n = 0; n < 180; n++) begin
            case ((p * 180 + n) * 3 / 1080)
               0: begin tx_idle = 38; rx_idle = 45; end
               1: begin tx_idle = 45; rx_idle = 38; end
               default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            if (p == 1 && n == 90) begin
               // hold off until the pipeline has emptied
               req_tvalid <= 0;
               @(posedge clock);
               while (board.expected_words.size() != 0) @(posedge clock);
            end
            send(random_scene());
         end
      end
      drain();
      $display("covered %0d view bases over six up vectors, including zero and extreme up",
               board.checked);
      $display("idling on either side, back-pressure and an emptied pipeline were exercised");
      if (board.errors == 0)
         $display("look_at_view_matrix_top regression: pass");
      else
         $display("look_at_view_matrix_top regression: fail");
      $finish;
   end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix_top.sv
tb/testbench.sv
